// ----- rtl/csc_pkg.sv -----
// Shared types, codes and constants for the cylinder stroke controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package csc_pkg;

  localparam int unsigned LevelW  = 8;
  localparam int unsigned TicksW  = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  localparam logic [LevelW-1:0] AutoExtendRst  = 8'd235;
  localparam logic [LevelW-1:0] AutoRetractRst = 8'd20;
  localparam logic [LevelW-1:0] ExtendedRst    = 8'd140;
  localparam logic [LevelW-1:0] RelayIdleRst   = 8'd240;
  localparam logic [TicksW-1:0] TimeoutRst     = 5'd20;

  localparam logic [7:0] CmdAck       = 8'd97;
  localparam logic [7:0] CmdManual    = 8'd109;
  localparam logic [7:0] CmdAuto      = 8'd110;
  localparam logic [7:0] CmdExtend    = 8'd111;
  localparam logic [7:0] CmdRetract   = 8'd107;
  localparam logic [7:0] CmdSelLevelA = 8'd114;
  localparam logic [7:0] CmdSelLevelB = 8'd115;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_EXTEND  = 3'd0,
    CFG_AUTO_RETRACT = 3'd1,
    CFG_EXTENDED     = 3'd2,
    CFG_RELAY_IDLE   = 3'd3,
    CFG_TIMEOUT      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_EXTEND  = 2'd1,
    PH_RETRACT = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_ACK           = 3'd0,
    ST_PRESSURE_LOW  = 3'd1,
    ST_EXTEND_RELAY  = 3'd2,
    ST_EXTEND_STALL  = 3'd3,
    ST_EXTENDED      = 3'd4,
    ST_RETRACT_RELAY = 3'd5,
    ST_RETRACT_STALL = 3'd6,
    ST_RETRACTED     = 3'd7
  } status_e;

  typedef struct packed {
    logic retract;
    logic extend;
    logic alarm;
  } drive_t;

  typedef struct packed {
    logic [LevelW-1:0] auto_extend_level;
    logic [LevelW-1:0] auto_retract_level;
    logic [LevelW-1:0] extended_level;
    logic [LevelW-1:0] relay_idle_level;
    logic [TicksW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [7:0]        rx_byte;
    logic              pressure_ok;
    logic [LevelW-1:0] level_a;
    logic [LevelW-1:0] extend_sensor;
    logic [LevelW-1:0] retract_sensor;
    logic [LevelW-1:0] retract_relay_sense;
    logic [LevelW-1:0] extend_relay_sense;
    logic [LevelW-1:0] level_b;
  } item_t;

  typedef struct packed {
    logic              manual_mode;
    logic              use_level_b;
    phase_e            phase;
    logic [TicksW-1:0] stroke_ticks;
    drive_t            drive;
  } state_t;

  typedef struct packed {
    logic    has_status;
    status_e status;
    logic    extend_valve;
    logic    retract_valve;
    logic    alarm;
    logic    last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/cylinder_stroke_controller_top.sv -----
// Top level of the pneumatic cylinder stroke controller.
// Depends on csc_pkg, csc_cfg_regs, csc_step and csc_out_buf.
//
// Each input beat is a tick with sensor samples or a received command byte and
// yields one or two result beats; the last one carries last_o. An accepted beat
// is captured in the input register, the step logic updates the mode, phase,
// tick count and drive state, and its results are registered into a two-entry
// output buffer, from which the first result is presented. The block
// takes one beat per cycle while each beat gives one result and the output is
// not stalled; a manual extend or retract command given while idle gives two
// results, and the buffer drains one beat per cycle when not stalled, so such a
// command stalls the input while both of its results are buffered.
`default_nettype none

module cylinder_stroke_controller_top
  import csc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               pressure_ok_i,
  input  wire logic [LevelW-1:0]  level_a_i,
  input  wire logic [LevelW-1:0]  extend_sensor_i,
  input  wire logic [LevelW-1:0]  retract_sensor_i,
  input  wire logic [LevelW-1:0]  retract_relay_sense_i,
  input  wire logic [LevelW-1:0]  extend_relay_sense_i,
  input  wire logic [LevelW-1:0]  level_b_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    has_status_o,
  output logic [2:0]              status_o,
  output logic                    extend_valve_o,
  output logic                    retract_valve_o,
  output logic                    alarm_o,
  output logic                    last_o
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  state_t  st_q, st_d;
  result_t res0, res1, res_out;
  logic    two;
  logic    buf_rdy;
  logic    adv;

  csc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign adv        = in_vld_q && buf_rdy;
  assign in_stall_o = in_vld_q && !buf_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q.command             <= command_i;
      in_q.rx_byte             <= rx_byte_i;
      in_q.pressure_ok         <= pressure_ok_i;
      in_q.level_a             <= level_a_i;
      in_q.extend_sensor       <= extend_sensor_i;
      in_q.retract_sensor      <= retract_sensor_i;
      in_q.retract_relay_sense <= retract_relay_sense_i;
      in_q.extend_relay_sense  <= extend_relay_sense_i;
      in_q.level_b             <= level_b_i;
    end
  end

  csc_step u_step (
    .item_i  (in_q),
    .state_i (st_q),
    .cfg_i   (cfg),
    .state_o (st_d),
    .res0_o  (res0),
    .res1_o  (res1),
    .two_o   (two)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.manual_mode  <= 1'b0;
      st_q.use_level_b  <= 1'b0;
      st_q.phase        <= PH_IDLE;
      st_q.stroke_ticks <= '0;
      st_q.drive        <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  csc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv),
    .two_i       (two),
    .res0_i      (res0),
    .res1_i      (res1),
    .ready_o     (buf_rdy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign has_status_o    = res_out.has_status;
  assign status_o        = res_out.status;
  assign extend_valve_o  = res_out.extend_valve;
  assign retract_valve_o = res_out.retract_valve;
  assign alarm_o         = res_out.alarm;
  assign last_o          = res_out.last;

  a_drive_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({extend_valve_o, retract_valve_o, alarm_o}) <= 1)
    else $error("more than one drive output active in a result beat");

  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_status_o) |-> (status_o == 3'd0))
    else $error("status code present without a status beat");

  a_idle_no_valve : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_IDLE) |-> (!st_q.drive.extend && !st_q.drive.retract))
    else $error("valve driven while no stroke is running");

  a_stroke_valve : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_EXTEND) |-> (st_q.drive.extend && !st_q.drive.alarm))
    else $error("extend stroke without its valve driven");

  a_stall_holds_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_stall_o) |-> (in_vld_q && $stable(in_q)))
    else $error("held input item lost or changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/csc_cfg_regs.sv -----
// Configuration register file for the cylinder stroke controller.
// Depends on csc_pkg for the register index codes and reset values.
`default_nettype none

module csc_cfg_regs
  import csc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AUTO_EXTEND:  cfg_d.auto_extend_level  = cfg_wdata_i[LevelW-1:0];
        CFG_AUTO_RETRACT: cfg_d.auto_retract_level = cfg_wdata_i[LevelW-1:0];
        CFG_EXTENDED:     cfg_d.extended_level     = cfg_wdata_i[LevelW-1:0];
        CFG_RELAY_IDLE:   cfg_d.relay_idle_level   = cfg_wdata_i[LevelW-1:0];
        CFG_TIMEOUT:      cfg_d.timeout_ticks      = cfg_wdata_i[TicksW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_extend_level  <= AutoExtendRst;
      cfg_q.auto_retract_level <= AutoRetractRst;
      cfg_q.extended_level     <= ExtendedRst;
      cfg_q.relay_idle_level   <= RelayIdleRst;
      cfg_q.timeout_ticks      <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/csc_step.sv -----
// Combinational step logic: one registered item and the current state give
// the next state and up to two result beats. Depends on csc_pkg.
`default_nettype none

module csc_step
  import csc_pkg::*;
(
  input  item_t   item_i,
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  output state_t  state_o,
  output result_t res0_o,
  output result_t res1_o,
  output logic    two_o
);

  state_t            nxt;
  logic              ack;
  logic              motion;
  logic              want_ext;
  logic              do_start;
  logic              start_ext;
  logic              st_has;
  status_e           st_code;
  logic [LevelW-1:0] level;
  logic              ext_conf;
  logic              ret_conf;
  logic [TicksW:0]   ticks_inc;

  assign level     = state_i.use_level_b ? item_i.level_b : item_i.level_a;
  assign ext_conf  = item_i.extend_sensor >= cfg_i.extended_level;
  assign ret_conf  = item_i.retract_sensor == '0;
  assign ticks_inc = {1'b0, state_i.stroke_ticks} + {{TicksW{1'b0}}, 1'b1};

  always_comb begin
    nxt       = state_i;
    ack       = 1'b0;
    motion    = 1'b0;
    want_ext  = 1'b0;
    do_start  = 1'b0;
    start_ext = 1'b0;
    st_has    = 1'b0;
    st_code   = ST_ACK;
    two_o     = 1'b0;

    if (!item_i.command) begin
      if (state_i.phase == PH_IDLE) begin
        if (!state_i.manual_mode) begin
          if (level > cfg_i.auto_extend_level) begin
            do_start  = 1'b1;
            start_ext = 1'b1;
          end else if (level < cfg_i.auto_retract_level) begin
            do_start  = 1'b1;
            start_ext = 1'b0;
          end
        end
      end else begin
        nxt.stroke_ticks = ticks_inc[TicksW-1:0];
        if (ticks_inc > {1'b0, cfg_i.timeout_ticks}) begin
          st_has = 1'b1;
          if (state_i.phase == PH_EXTEND) begin
            st_code = (item_i.extend_relay_sense > cfg_i.relay_idle_level) ?
                      ST_EXTEND_RELAY : ST_EXTEND_STALL;
          end else begin
            st_code = (item_i.retract_relay_sense > cfg_i.relay_idle_level) ?
                      ST_RETRACT_RELAY : ST_RETRACT_STALL;
          end
          nxt.drive = '{retract: 1'b0, extend: 1'b0, alarm: 1'b1};
          nxt.phase = PH_IDLE;
        end else if (state_i.phase == PH_EXTEND && ext_conf) begin
          st_has    = 1'b1;
          st_code   = ST_EXTENDED;
          nxt.drive = '0;
          nxt.phase = PH_IDLE;
        end else if (state_i.phase == PH_RETRACT && ret_conf) begin
          st_has    = 1'b1;
          st_code   = ST_RETRACTED;
          nxt.drive = '0;
          nxt.phase = PH_IDLE;
        end
      end
    end else begin
      ack = 1'b1;
      unique case (item_i.rx_byte)
        CmdAck:       ack = 1'b1;
        CmdManual:    nxt.manual_mode = 1'b1;
        CmdAuto:      nxt.manual_mode = 1'b0;
        CmdExtend: begin
          motion   = 1'b1;
          want_ext = 1'b1;
        end
        CmdRetract:   motion = 1'b1;
        CmdSelLevelA: nxt.use_level_b = 1'b0;
        CmdSelLevelB: nxt.use_level_b = 1'b1;
        default:      ack = 1'b0;
      endcase
      if (motion && nxt.manual_mode && state_i.phase == PH_IDLE) begin
        two_o     = 1'b1;
        do_start  = 1'b1;
        start_ext = want_ext;
      end
    end

    if (do_start) begin
      if (!item_i.pressure_ok) begin
        st_has  = 1'b1;
        st_code = ST_PRESSURE_LOW;
      end else begin
        nxt.stroke_ticks = '0;
        if (start_ext) begin
          nxt.drive = '{retract: 1'b0, extend: 1'b1, alarm: 1'b0};
          nxt.phase = PH_EXTEND;
          if (ext_conf) begin
            st_has    = 1'b1;
            st_code   = ST_EXTENDED;
            nxt.drive = '0;
            nxt.phase = PH_IDLE;
          end
        end else begin
          nxt.drive = '{retract: 1'b1, extend: 1'b0, alarm: 1'b0};
          nxt.phase = PH_RETRACT;
          if (ret_conf) begin
            st_has    = 1'b1;
            st_code   = ST_RETRACTED;
            nxt.drive = '0;
            nxt.phase = PH_IDLE;
          end
        end
      end
    end
  end

  always_comb begin
    res0_o = '0;
    res1_o = '0;
    if (item_i.command) begin
      res0_o.has_status    = ack;
      res0_o.status        = ST_ACK;
      res0_o.extend_valve  = state_i.drive.extend;
      res0_o.retract_valve = state_i.drive.retract;
      res0_o.alarm         = state_i.drive.alarm;
      res0_o.last          = !two_o;
      res1_o.has_status    = st_has;
      res1_o.status        = st_has ? st_code : ST_ACK;
      res1_o.extend_valve  = nxt.drive.extend;
      res1_o.retract_valve = nxt.drive.retract;
      res1_o.alarm         = nxt.drive.alarm;
      res1_o.last          = 1'b1;
    end else begin
      res0_o.has_status    = st_has;
      res0_o.status        = st_has ? st_code : ST_ACK;
      res0_o.extend_valve  = nxt.drive.extend;
      res0_o.retract_valve = nxt.drive.retract;
      res0_o.alarm         = nxt.drive.alarm;
      res0_o.last          = 1'b1;
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// ----- rtl/csc_out_buf.sv -----
// Two-entry result buffer that sends one or two beats per item in order.
// Depends on csc_pkg for the result type.
`default_nettype none

module csc_out_buf
  import csc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire logic two_i,
  input  result_t   res0_i,
  input  result_t   res1_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output result_t   res_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    s0_q, s0_d;
  result_t    s1_q, s1_d;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign ready_o     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d = cnt_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    if (push_i) begin
      s0_d  = res0_i;
      s1_d  = res1_i;
      cnt_d = two_i ? 2'd2 : 2'd1;
    end else if (pop) begin
      s0_d  = s1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign res_o = s0_q;

endmodule

`default_nettype wire

// ----- test/cylinder_stroke_controller_top_tb.sv -----
// Self-checking testbench for cylinder_stroke_controller_top: a queue-fed driver
// and a clocked monitor check every result beat against a cycle-free predictor.
// Depends on csc_pkg and the controller RTL only.
`timescale 1ns / 100ps

module cylinder_stroke_controller_top_tb;
  import csc_pkg::*;

  localparam int unsigned QuietLimit = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = 1'b0;
  logic [7:0]         rx_byte_i = '0;
  logic               pressure_ok_i = 1'b0;
  logic [LevelW-1:0]  level_a_i = '0;
  logic [LevelW-1:0]  extend_sensor_i = '0;
  logic [LevelW-1:0]  retract_sensor_i = '0;
  logic [LevelW-1:0]  retract_relay_sense_i = '0;
  logic [LevelW-1:0]  extend_relay_sense_i = '0;
  logic [LevelW-1:0]  level_b_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               has_status_o;
  logic [2:0]         status_o;
  logic               extend_valve_o;
  logic               retract_valve_o;
  logic               alarm_o;
  logic               last_o;

  cylinder_stroke_controller_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .command_i            (command_i),
    .rx_byte_i            (rx_byte_i),
    .pressure_ok_i        (pressure_ok_i),
    .level_a_i            (level_a_i),
    .extend_sensor_i      (extend_sensor_i),
    .retract_sensor_i     (retract_sensor_i),
    .retract_relay_sense_i(retract_relay_sense_i),
    .extend_relay_sense_i (extend_relay_sense_i),
    .level_b_i            (level_b_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .has_status_o         (has_status_o),
    .status_o             (status_o),
    .extend_valve_o       (extend_valve_o),
    .retract_valve_o      (retract_valve_o),
    .alarm_o              (alarm_o),
    .last_o               (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t   item_backlog[$];
  result_t due_results[$];
  item_t   cur_item;
  int      n_queued = 0;
  int      n_taken = 0;
  int      n_bad = 0;
  int      send_idle_pct = 11;
  int      recv_stall_pct = 65;
  int      confirm_pct = 30;
  bit      drain_hold = 1'b0;

  cfg_t              lim;
  logic              m_manual;
  logic              m_level_b;
  phase_e            m_phase;
  logic [TicksW-1:0] m_ticks;
  drive_t            m_drive;

  logic [7:0] cmd_pool [9];

  function automatic void emit_result(bit has, int st, bit fin);
    result_t r;
    r.has_status    = has;
    r.status        = has ? status_e'(st[2:0]) : ST_ACK;
    r.extend_valve  = m_drive.extend;
    r.retract_valve = m_drive.retract;
    r.alarm         = m_drive.alarm;
    r.last          = fin;
    due_results.push_back(r);
  endfunction

  function automatic int position_confirm(item_t it);
    if (m_phase == PH_EXTEND && it.extend_sensor >= lim.extended_level) begin
      m_drive = '0;
      m_phase = PH_IDLE;
      return ST_EXTENDED;
    end
    if (m_phase == PH_RETRACT && it.retract_sensor == 8'd0) begin
      m_drive = '0;
      m_phase = PH_IDLE;
      return ST_RETRACTED;
    end
    return -1;
  endfunction

  function automatic int begin_stroke(item_t it, bit ext);
    if (!it.pressure_ok) return ST_PRESSURE_LOW;
    m_drive = '0;
    if (ext) begin
      m_drive.extend = 1'b1;
      m_phase = PH_EXTEND;
    end else begin
      m_drive.retract = 1'b1;
      m_phase = PH_RETRACT;
    end
    m_ticks = '0;
    return position_confirm(it);
  endfunction

  function automatic int stroke_tick(item_t it);
    logic [5:0] n;
    int st;
    n = {1'b0, m_ticks} + 6'd1;
    m_ticks = n[TicksW-1:0];
    if (n > {1'b0, lim.timeout_ticks}) begin
      if (m_phase == PH_EXTEND) begin
        st = (it.extend_relay_sense > lim.relay_idle_level) ? ST_EXTEND_RELAY : ST_EXTEND_STALL;
      end else begin
        st = (it.retract_relay_sense > lim.relay_idle_level) ? ST_RETRACT_RELAY
                                                             : ST_RETRACT_STALL;
      end
      m_drive = '0;
      m_drive.alarm = 1'b1;
      m_phase = PH_IDLE;
      return st;
    end
    return position_confirm(it);
  endfunction

  function automatic void advance_cylinder(item_t it);
    int st;
    logic [7:0] lv;
    bit ack;
    bit motion;
    bit ext;
    bit second;
    st = -1;
    if (!it.command) begin
      if (m_phase == PH_IDLE) begin
        if (!m_manual) begin
          lv = m_level_b ? it.level_b : it.level_a;
          if (lv > lim.auto_extend_level) begin
            st = begin_stroke(it, 1'b1);
          end else if (lv < lim.auto_retract_level) begin
            st = begin_stroke(it, 1'b0);
          end
        end
      end else begin
        st = stroke_tick(it);
      end
      emit_result(st >= 0, st, 1'b1);
    end else begin
      ack = 1'b1;
      motion = 1'b0;
      ext = 1'b0;
      case (it.rx_byte)
        CmdAck:       ack = 1'b1;
        CmdManual:    m_manual = 1'b1;
        CmdAuto:      m_manual = 1'b0;
        CmdExtend: begin
          motion = 1'b1;
          ext = 1'b1;
        end
        CmdRetract:   motion = 1'b1;
        CmdSelLevelA: m_level_b = 1'b0;
        CmdSelLevelB: m_level_b = 1'b1;
        default:      ack = 1'b0;
      endcase
      second = motion && m_manual && (m_phase == PH_IDLE);
      emit_result(ack, ST_ACK, !second);
      if (second) begin
        st = begin_stroke(it, ext);
        emit_result(st >= 0, st, 1'b1);
      end
    end
  endfunction

  function automatic logic [7:0] random_level();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30 && lim.auto_retract_level != 8'd0) begin
      return 8'($urandom_range(lim.auto_retract_level - 1, 0));
    end
    if (pick >= 70 && lim.auto_extend_level != 8'hff) begin
      return 8'($urandom_range(255, lim.auto_extend_level + 1));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] random_sense();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 8'd0;
    if (pick < 20) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.command     = ($urandom_range(99) < 25);
    it.rx_byte     = ($urandom_range(99) < 80) ? cmd_pool[$urandom_range(8)]
                                               : 8'($urandom_range(255));
    it.pressure_ok = ($urandom_range(99) < 90);
    it.level_a     = random_level();
    it.level_b     = random_level();
    if ($urandom_range(99) < confirm_pct) begin
      it.extend_sensor = 8'($urandom_range(255, lim.extended_level));
    end else if (lim.extended_level != 8'd0) begin
      it.extend_sensor = 8'($urandom_range(lim.extended_level - 1, 0));
    end else begin
      it.extend_sensor = 8'($urandom_range(255));
    end
    it.retract_sensor = ($urandom_range(99) < confirm_pct) ? 8'd0 : 8'($urandom_range(255, 1));
    it.retract_relay_sense = random_sense();
    it.extend_relay_sense  = random_sense();
    return it;
  endfunction

  function automatic item_t make_item(bit cmd, logic [7:0] b, bit p, logic [7:0] la,
                                      logic [7:0] lb, logic [7:0] es, logic [7:0] rs,
                                      logic [7:0] rrs, logic [7:0] ers);
    item_t it;
    it.command             = cmd;
    it.rx_byte             = b;
    it.pressure_ok         = p;
    it.level_a             = la;
    it.level_b             = lb;
    it.extend_sensor       = es;
    it.retract_sensor      = rs;
    it.retract_relay_sense = rrs;
    it.extend_relay_sense  = ers;
    return it;
  endfunction

  task automatic queue_item(item_t it);
    item_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_AUTO_EXTEND:  lim.auto_extend_level  = val;
      CFG_AUTO_RETRACT: lim.auto_retract_level = val;
      CFG_EXTENDED:     lim.extended_level     = val;
      CFG_RELAY_IDLE:   lim.relay_idle_level   = val;
      CFG_TIMEOUT:      lim.timeout_ticks      = val[TicksW-1:0];
      default:          ;
    endcase
  endtask

  task automatic write_all(logic [7:0] ae, logic [7:0] ar, logic [7:0] ex, logic [7:0] ri,
                           logic [7:0] tmo);
    write_reg(CFG_AUTO_EXTEND, ae);
    write_reg(CFG_AUTO_RETRACT, ar);
    write_reg(CFG_EXTENDED, ex);
    write_reg(CFG_RELAY_IDLE, ri);
    write_reg(CFG_TIMEOUT, tmo);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    bit go;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        advance_cylinder(cur_item);
        n_taken++;
        if (n_taken % 60 == 0) drain_hold = 1'b1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (drain_hold && due_results.size() == 0) drain_hold = 1'b0;
        go = item_backlog.size() != 0 && !drain_hold &&
             ($urandom_range(99) >= send_idle_pct);
        if (go) begin
          cur_item = item_backlog.pop_front();
          in_valid_i            <= 1'b1;
          command_i             <= cur_item.command;
          rx_byte_i             <= cur_item.rx_byte;
          pressure_ok_i         <= cur_item.pressure_ok;
          level_a_i             <= cur_item.level_a;
          extend_sensor_i       <= cur_item.extend_sensor;
          retract_sensor_i      <= cur_item.retract_sensor;
          retract_relay_sense_i <= cur_item.retract_relay_sense;
          extend_relay_sense_i  <= cur_item.extend_relay_sense;
          level_b_i             <= cur_item.level_b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.has_status    = has_status_o;
        got.status        = status_e'(status_o);
        got.extend_valve  = extend_valve_o;
        got.retract_valve = retract_valve_o;
        got.alarm         = alarm_o;
        got.last          = last_o;
        if (due_results.size() == 0) begin
          if (n_bad < 10) $display("%0t: result beat with nothing expected", $time);
          n_bad++;
        end else begin
          want = due_results.pop_front();
          if (got.has_status !== want.has_status || got.status !== want.status ||
              got.extend_valve !== want.extend_valve ||
              got.retract_valve !== want.retract_valve ||
              got.alarm !== want.alarm || got.last !== want.last) begin
            if (n_bad < 10) begin
              $display("%0t: expected has=%0d st=%0d ext=%0d ret=%0d alm=%0d last=%0d",
                       $time, want.has_status, want.status, want.extend_valve,
                       want.retract_valve, want.alarm, want.last);
              $display("%0t: got      has=%0d st=%0d ext=%0d ret=%0d alm=%0d last=%0d",
                       $time, got.has_status, got.status, got.extend_valve,
                       got.retract_valve, got.alarm, got.last);
            end
            n_bad++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    int unsigned quiet;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int s;
    cmd_pool = '{CmdAck, CmdManual, CmdAuto, CmdExtend, CmdExtend, CmdRetract, CmdRetract,
                 CmdSelLevelA, CmdSelLevelB};
    lim = '{AutoExtendRst, AutoRetractRst, ExtendedRst, RelayIdleRst, TimeoutRst};
    m_manual  = 1'b0;
    m_level_b = 1'b0;
    m_phase   = PH_IDLE;
    m_ticks   = '0;
    m_drive   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(make_item(0, 8'h00, 1, 8'd128, 8'd0, 8'd0, 8'hff, 8'd0, 8'd0));
    queue_item(make_item(1, CmdAck, 0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_item(make_item(1, 8'h00, 1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    queue_item(make_item(1, 8'hff, 0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_item(make_item(1, CmdSelLevelB, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(0, 8'h55, 0, 8'd0, 8'hff, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(0, 8'haa, 1, 8'd0, 8'hff, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(1, CmdManual, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(1, CmdExtend, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd0, 8'd139, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd0, 8'd140, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(1, CmdSelLevelA, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(1, CmdAuto, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_item(make_item(1, CmdManual, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(1, CmdRetract, 0, 8'd0, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0));
    queue_item(make_item(1, CmdRetract, 1, 8'd0, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0));
    queue_item(make_item(1, CmdRetract, 1, 8'd0, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    wait_drained();

    // A one-tick timeout makes the relay and stall faults reachable in a few beats.
    write_reg(CFG_TIMEOUT, 8'd1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    queue_item(make_item(1, CmdExtend, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'hff));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'hff));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'hff));
    queue_item(make_item(1, CmdExtend, 0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
    queue_item(make_item(1, CmdRetract, 1, 8'd0, 8'd0, 8'd0, 8'd9, 8'd0, 8'd0));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd0, 8'd0, 8'd9, 8'd0, 8'd0));
    queue_item(make_item(0, 8'h00, 1, 8'd0, 8'd0, 8'd0, 8'd9, 8'd0, 8'd0));
    wait_drained();

    for (s = 0; s < 7; s++) begin
      if (s == 2) begin
        send_idle_pct  = 65;
        recv_stall_pct = 11;
      end else if (s == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (s == 0) begin
        write_all(8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
        confirm_pct = 30;
      end else if (s == 1) begin
        write_all(8'd255, 8'd0, 8'd255, 8'd255, 8'd30);
        confirm_pct = 3;
      end else begin
        write_all(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(8)));
        confirm_pct = 15;
      end
      repeat (100) queue_item(random_item());
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (n_bad == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/csc_pkg.sv
rtl/csc_cfg_regs.sv
rtl/csc_step.sv
rtl/csc_out_buf.sv
rtl/cylinder_stroke_controller_top.sv
test/cylinder_stroke_controller_top_tb.sv
